// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL; clk and rst must be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define MEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Expression holds at every edge out of reset.
`define MEP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

// ===== hdl/mep_pkg.sv =====
// Shared types and constants of the escape-time pixel block.
`default_nettype none
package mep_pkg;

  localparam int REG_W     = 32;
  localparam int STEP_W    = 31;
  localparam int LIMIT_W   = 16;
  localparam int GRAY_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int QUO_W     = 9;   // quotient bits resolved by the divide chain
  localparam int DEN_W     = 33;  // 2*d*d
  localparam int NUM_W     = 43;  // 510*n*n + d*d

  localparam logic [LIMIT_W-1:0] LIMIT_FLOOR = 16'd2;
  localparam logic [GRAY_W-1:0]  GRAY_MAX    = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_PIXEL_STEP,
    REG_ITER_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_BUSY,
    TOP_HOLD
  } top_state_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_COORD,
    OP_MUL,
    OP_STEP
  } orbit_state_t;

  typedef struct packed {
    logic               valid;
    logic [LIMIT_W-1:0] count;
  } orbit_result_t;

  typedef struct packed {
    logic               valid;
    logic [NUM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [QUO_W-1:0]   quo;
    logic [LIMIT_W-1:0] count;
  } div_stage_t;

endpackage
`default_nettype wire

// ===== hdl/mep_pixel_if.sv =====
// Pixel request channel: valid/ready with column and row.
`default_nettype none
interface mep_pixel_if #(parameter int PIXEL_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_column;
  logic [PIXEL_BITS-1:0] pixel_row;

  modport source (output valid, pixel_column, pixel_row, input ready);
  modport sink   (input valid, pixel_column, pixel_row, output ready);
endinterface
`default_nettype wire

// ===== hdl/mep_result_if.sv =====
// Result channel: valid/ready with gray level and iteration count.
`default_nettype none
interface mep_result_if;
  logic                          valid;
  logic                          ready;
  logic [mep_pkg::GRAY_W-1:0]    gray_level;
  logic [mep_pkg::LIMIT_W-1:0]   iteration_count;

  modport source (output valid, gray_level, iteration_count, input ready);
  modport sink   (input valid, gray_level, iteration_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/mandelbrot_escape_pixel.sv =====
// Top level of the escape-time pixel block: config registers, control and output stage.
//
//  channel      dir  handshake          payload
//  pixel_in     in   valid / ready      pixel_column, pixel_row
//  result_out   out  valid / ready      gray_level, iteration_count
//  cfg_*        in   cfg_write (no wait) cfg_index, cfg_data
//
// One pixel is worked on at a time. Its steps are: map the point, a squarer/update pair
// per iteration (a point that escapes takes one pair more than its count, for the failing
// test), square the shading terms, form the shading fraction, the nine cells of the divide
// chain, and the output register.
// Reset is synchronous on rst and restores the default view and a limit of 20.
// pixel_in is ready in idle, also while a finished transaction still waits on result_out;
// a second result finishing under a stalled output parks in a holding register.
`default_nettype none
`include "assert_macros.svh"
module mandelbrot_escape_pixel #(
  parameter int COORD_BITS = 32,
  parameter int PIXEL_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  mep_pixel_if.sink                       pixel_in,
  mep_result_if.source                    result_out,
  input  logic                            cfg_write,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mep_pkg::REG_W-1:0]       cfg_data
);

  // configuration registers
  logic [mep_pkg::REG_W-1:0]   origin_x, origin_y;
  logic [mep_pkg::STEP_W-1:0]  pixel_step;
  logic [mep_pkg::LIMIT_W-1:0] iteration_limit;
  logic [mep_pkg::LIMIT_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= 32'hD800_0000;
      origin_y        <= 32'hE800_0000;
      pixel_step      <= 31'd1342177;
      iteration_limit <= 16'd20;
    end else if (cfg_write) begin
      unique case (mep_pkg::cfg_reg_t'(cfg_index))
        mep_pkg::REG_ORIGIN_X:   origin_x        <= cfg_data;
        mep_pkg::REG_ORIGIN_Y:   origin_y        <= cfg_data;
        mep_pkg::REG_PIXEL_STEP: pixel_step      <= cfg_data[mep_pkg::STEP_W-1:0];
        mep_pkg::REG_ITER_LIMIT: iteration_limit <= cfg_data[mep_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // limits of 0 and 1 behave as 2
  assign lim = (iteration_limit < mep_pkg::LIMIT_FLOOR) ? mep_pkg::LIMIT_FLOOR
                                                         : iteration_limit;

  mep_pkg::top_state_t    state, state_next;
  mep_pkg::orbit_result_t orbit_res;
  mep_pkg::div_stage_t    shade_res;
  logic                   accept, out_free, load_chain, load_pend;
  logic [mep_pkg::GRAY_W-1:0]  chain_gray, pend_gray;
  logic [mep_pkg::LIMIT_W-1:0] pend_count;

  assign accept   = pixel_in.valid && pixel_in.ready;
  assign out_free = !result_out.valid || result_out.ready;

  mep_orbit #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_orbit (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .pixel_column (pixel_in.pixel_column),
    .pixel_row    (pixel_in.pixel_row),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .pixel_step   (pixel_step),
    .limit        (lim),
    .result       (orbit_res)
  );

  mep_shade u_shade (
    .clk    (clk),
    .rst    (rst),
    .start  (orbit_res),
    .limit  (lim),
    .result (shade_res)
  );

  // quotient tops out at 255; clamp kept for the spare top bit
  assign chain_gray = (shade_res.quo > mep_pkg::QUO_W'(mep_pkg::GRAY_MAX))
                    ? mep_pkg::GRAY_MAX : shade_res.quo[mep_pkg::GRAY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mep_pkg::TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    pixel_in.ready = 1'b0;
    load_chain     = 1'b0;
    load_pend      = 1'b0;
    unique case (state)
      mep_pkg::TOP_IDLE: begin
        pixel_in.ready = 1'b1;
        if (pixel_in.valid) state_next = mep_pkg::TOP_BUSY;
      end
      mep_pkg::TOP_BUSY: begin
        if (shade_res.valid) begin
          if (out_free) begin
            load_chain = 1'b1;
            state_next = mep_pkg::TOP_IDLE;
          end else begin
            state_next = mep_pkg::TOP_HOLD;
          end
        end
      end
      mep_pkg::TOP_HOLD: begin
        if (out_free) begin
          load_pend  = 1'b1;
          state_next = mep_pkg::TOP_IDLE;
        end
      end
      default: state_next = mep_pkg::TOP_IDLE;
    endcase
  end

  // holding register, written when a result lands on a stalled output
  always_ff @(posedge clk) begin
    if (state == mep_pkg::TOP_BUSY && shade_res.valid && !out_free) begin
      pend_gray  <= chain_gray;
      pend_count <= shade_res.count;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (load_chain || load_pend) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_chain) begin
      result_out.gray_level      <= chain_gray;
      result_out.iteration_count <= shade_res.count;
    end else if (load_pend) begin
      result_out.gray_level      <= pend_gray;
      result_out.iteration_count <= pend_count;
    end
  end

  // a point that never escaped shades black
  `MEP_ASSERT_IMP(a_limit_black,
    result_out.valid && result_out.iteration_count == lim, result_out.gray_level == 8'd0)
  // a point that escaped at once shades white
  `MEP_ASSERT_IMP(a_first_white,
    result_out.valid && result_out.iteration_count == 16'd1,
    result_out.gray_level == mep_pkg::GRAY_MAX)
  // count stays within 1..limit
  `MEP_ASSERT_IMP(a_count_range, result_out.valid,
    result_out.iteration_count != 16'd0 && result_out.iteration_count <= lim)
  // holding only happens behind a full output register
  `MEP_ASSERT_IMP(a_hold_full, state == mep_pkg::TOP_HOLD, result_out.valid)

endmodule
`default_nettype wire

// ===== hdl/mep_orbit.sv =====
// Point mapping and escape-time iteration, each iteration a multiply state then an update state.
`default_nettype none
module mep_orbit #(
  parameter int COORD_BITS = 32,
  parameter int PIXEL_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [PIXEL_BITS-1:0]               pixel_column,
  input  logic [PIXEL_BITS-1:0]               pixel_row,
  input  logic [mep_pkg::REG_W-1:0]           origin_x,
  input  logic [mep_pkg::REG_W-1:0]           origin_y,
  input  logic [mep_pkg::STEP_W-1:0]          pixel_step,
  input  logic [mep_pkg::LIMIT_W-1:0]         limit,
  output mep_pkg::orbit_result_t              result
);

  localparam int F  = COORD_BITS - 4;
  localparam int PW = 2 * COORD_BITS;
  localparam int MW = mep_pkg::STEP_W + PIXEL_BITS;
  localparam int VW = MW + 2;
  localparam logic [COORD_BITS-2:0] FOUR = {1'b1, {(COORD_BITS-2){1'b0}}};

  mep_pkg::orbit_state_t state, state_next;

  logic [PIXEL_BITS-1:0]        col, row;
  logic signed [COORD_BITS-1:0] x0, y0, x, y;
  logic signed [PW-1:0]         pxx, pyy, pxy;
  logic [mep_pkg::LIMIT_W-1:0]  count;

  // saturate to the Q4.28 register range
  function automatic logic [31:0] sat32(input logic [VW-1:0] v);
    logic [VW-32:0] top;
    top = v[VW-1:31];
    if ((&top) || !(|top)) return v[31:0];
    return {v[VW-1], {31{~v[VW-1]}}};
  endfunction

  logic [MW-1:0]         prod_x, prod_y;
  logic [VW-1:0]         sum_x, sum_y;
  logic [31:0]           v32_x, v32_y;
  logic [COORD_BITS-1:0] cx, cy;

  assign prod_x = pixel_step * col;
  assign prod_y = pixel_step * row;
  assign sum_x  = {{(VW-32){origin_x[31]}}, origin_x} + {2'b00, prod_x};
  assign sum_y  = {{(VW-32){origin_y[31]}}, origin_y} + {2'b00, prod_y};
  assign v32_x  = sat32(sum_x);
  assign v32_y  = sat32(sum_y);

  generate
    if (COORD_BITS >= 32) begin : g_widen
      assign cx = COORD_BITS'($signed(v32_x)) << (COORD_BITS - 32);
      assign cy = COORD_BITS'($signed(v32_y)) << (COORD_BITS - 32);
    end else begin : g_narrow
      // floor shift: keep the top bits
      assign cx = v32_x[31 -: COORD_BITS];
      assign cy = v32_y[31 -: COORD_BITS];
    end
  endgenerate

  // squares, capped at four
  logic [PW-F-1:0]       sq_x, sq_y;
  logic [COORD_BITS-2:0] x2, y2;
  logic                  in_bound;

  assign sq_x = pxx[PW-1:F];
  assign sq_y = pyy[PW-1:F];
  assign x2   = (sq_x > {5'b00000, FOUR}) ? FOUR : sq_x[COORD_BITS-2:0];
  assign y2   = (sq_y > {5'b00000, FOUR}) ? FOUR : sq_y[COORD_BITS-2:0];
  assign in_bound = ({1'b0, x2} + {1'b0, y2}) < {1'b0, FOUR};

  // next orbit point, saturated to the coordinate range
  logic signed [PW-1:0]     pxy_sh;
  logic [PW:0]              ysum;
  logic [COORD_BITS+1:0]    xsum;
  logic [COORD_BITS-1:0]    nx, ny;
  logic [PW-COORD_BITS+1:0] ytop;
  logic [2:0]               xtop;

  assign pxy_sh = pxy >>> (F - 1);
  assign ysum   = {pxy_sh[PW-1], pxy_sh} + {{(PW+1-COORD_BITS){y0[COORD_BITS-1]}}, y0};
  assign xsum   = {3'b000, x2} - {3'b000, y2} + {{2{x0[COORD_BITS-1]}}, x0};
  assign ytop   = ysum[PW:COORD_BITS-1];
  assign xtop   = xsum[COORD_BITS+1:COORD_BITS-1];
  assign ny = ((&ytop) || !(|ytop)) ? ysum[COORD_BITS-1:0]
            : {ysum[PW], {(COORD_BITS-1){~ysum[PW]}}};
  assign nx = ((&xtop) || !(|xtop)) ? xsum[COORD_BITS-1:0]
            : {xsum[COORD_BITS+1], {(COORD_BITS-1){~xsum[COORD_BITS+1]}}};

  logic [mep_pkg::LIMIT_W:0] count_inc;
  logic                      at_limit;

  assign count_inc = {1'b0, count} + 1'b1;
  assign at_limit  = count_inc >= {1'b0, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mep_pkg::OP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    result.valid = 1'b0;
    result.count = count;
    unique case (state)
      mep_pkg::OP_IDLE: begin
        if (start) state_next = mep_pkg::OP_COORD;
      end
      mep_pkg::OP_COORD: begin
        state_next = mep_pkg::OP_MUL;
      end
      mep_pkg::OP_MUL: begin
        state_next = mep_pkg::OP_STEP;
      end
      mep_pkg::OP_STEP: begin
        if (!in_bound) begin
          result.valid = 1'b1;
          state_next   = mep_pkg::OP_IDLE;
        end else if (at_limit) begin
          result.valid = 1'b1;
          result.count = limit;
          state_next   = mep_pkg::OP_IDLE;
        end else begin
          state_next = mep_pkg::OP_MUL;
        end
      end
      default: state_next = mep_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == mep_pkg::OP_IDLE && start) begin
      col <= pixel_column;
      row <= pixel_row;
    end
    if (state == mep_pkg::OP_COORD) begin
      x0    <= cx;
      y0    <= cy;
      x     <= '0;
      y     <= '0;
      count <= '0;
    end
    if (state == mep_pkg::OP_MUL) begin
      pxx <= x * x;
      pyy <= y * y;
      pxy <= x * y;
    end
    if (state == mep_pkg::OP_STEP && in_bound && !at_limit) begin
      x     <= nx;
      y     <= ny;
      count <= count_inc[mep_pkg::LIMIT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mep_div_cell.sv =====
// One restoring-division cell: trial subtract of the shifted divisor.
`default_nettype none
module mep_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  mep_pkg::div_stage_t din,
  output mep_pkg::div_stage_t dout
);

  logic [mep_pkg::NUM_W-1:0] dsh;
  logic [mep_pkg::NUM_W:0]   trial;

  assign dsh   = mep_pkg::NUM_W'(din.den) << SHIFT;
  assign trial = {1'b0, din.rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.den   <= din.den;
    dout.count <= din.count;
    if (!trial[mep_pkg::NUM_W]) begin
      dout.rem <= trial[mep_pkg::NUM_W-1:0];
      dout.quo <= din.quo | (mep_pkg::QUO_W'(1) << SHIFT);
    end else begin
      dout.rem <= din.rem;
      dout.quo <= din.quo;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mep_shade.sv =====
// Gray-level shading: squares, then a chain of division cells.
`default_nettype none
`include "assert_macros.svh"
module mep_shade (
  input  logic                         clk,
  input  logic                         rst,
  input  mep_pkg::orbit_result_t       start,
  input  logic [mep_pkg::LIMIT_W-1:0]  limit,
  output mep_pkg::div_stage_t          result
);

  localparam int CELLS = mep_pkg::QUO_W;

  logic [mep_pkg::LIMIT_W-1:0]   n, d;
  logic                          sq_valid;
  logic [2*mep_pkg::LIMIT_W-1:0] nn, dd;
  logic [mep_pkg::LIMIT_W-1:0]   sq_count;

  assign n = limit - start.count;
  assign d = limit - 1'b1;

  mep_pkg::div_stage_t chain [CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid       <= 1'b0;
      chain[0].valid <= 1'b0;
    end else begin
      sq_valid       <= start.valid;
      chain[0].valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    nn       <= n * n;
    dd       <= d * d;
    sq_count <= start.count;
    // 510*n*n + d*d over 2*d*d
    chain[0].rem   <= (mep_pkg::NUM_W'(nn) << 9) - (mep_pkg::NUM_W'(nn) << 1)
                      + mep_pkg::NUM_W'(dd);
    chain[0].den   <= {dd, 1'b0};
    chain[0].quo   <= '0;
    chain[0].count <= sq_count;
  end

  genvar k;
  generate
    for (k = 0; k < CELLS; k++) begin : g_cell
      mep_div_cell #(.SHIFT(CELLS - 1 - k)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .din  (chain[k]),
        .dout (chain[k+1])
      );
    end
  endgenerate

  assign result = chain[CELLS];

  logic [CELLS+1:0] busy_vec;
  always_comb begin
    busy_vec[0] = sq_valid;
    for (int i = 0; i <= CELLS; i++) busy_vec[i+1] = chain[i].valid;
  end

  // one pixel in flight at a time
  `MEP_ASSERT_ALWAYS(a_single_item, $onehot0(busy_vec))

endmodule
`default_nettype wire

// ===== tb/mandelbrot_escape_pixel_test.sv =====
// Self-checking test of the escape-time pixel block: directed and random pixels over several views.
`timescale 1ns / 100ps
`default_nettype none
module mandelbrot_escape_pixel_test;

  localparam int FRAC = 28;
  localparam longint FOUR_Q = 64'sd1 << (FRAC + 2);
  localparam longint C_MAX = 64'sd2147483647;
  localparam longint C_MIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 64'd12000000;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  gray;
    logic [15:0] count;
  } shade_t;

  // One queued transaction, or a view change / drain marker.
  typedef struct {
    bit                 is_cfg;
    bit                 drain;
    mep_pkg::cfg_reg_t  reg_idx;
    logic [31:0]        value;
    pixel_t             pix;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mep_pkg::REG_W-1:0] cfg_data = '0;

  mep_pixel_if #(.PIXEL_BITS(12)) pixel_ch ();
  mep_result_if result_ch ();

  mandelbrot_escape_pixel #(.COORD_BITS(32), .PIXEL_BITS(12)) DUT (
    .clk(clk), .rst(rst), .pixel_in(pixel_ch.sink), .result_out(result_ch.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor's copy of the view registers
  longint view_x, view_y, view_step;
  int unsigned view_limit;

  job_t   job_q[$];
  shade_t shade_q[$];
  int     errors = 0;
  bit     stim_done = 0;
  longint cycles = 0;
  int     hold = 0;   // wait-out cycles at a drain marker, once every result is in

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_c(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  // floor(a*b / 2^k) at full width; operands fit 32 bits so 128 bits is exact
  function automatic longint prod_floor(longint a, longint b, int k);
    logic signed [127:0] p;
    p = $signed(128'(a)) * $signed(128'(b));
    p = p >>> k;
    return longint'(p);
  endfunction

  function automatic longint map_point(longint org, logic [11:0] pos);
    longint v;
    v = org + view_step * longint'(pos);
    if (v > C_MAX) v = C_MAX;
    if (v < C_MIN) v = C_MIN;
    return v;
  endfunction

  function automatic shade_t escape_shade(pixel_t p);
    longint x0, y0, x, y, x2, y2, ny;
    longint unsigned lim, n, d, g;
    longint unsigned count;
    shade_t r;
    lim = (view_limit < 2) ? 2 : view_limit;
    x0 = map_point(view_x, p.column);
    y0 = map_point(view_y, p.row);
    x = 0; y = 0; x2 = 0; y2 = 0; count = 0;
    while (x2 + y2 < FOUR_Q) begin
      ny = clamp_c(prod_floor(x, y, FRAC - 1) + y0);
      x = clamp_c(x2 - y2 + x0);
      y = ny;
      x2 = prod_floor(x, x, FRAC);
      y2 = prod_floor(y, y, FRAC);
      if (x2 > FOUR_Q) x2 = FOUR_Q;
      if (y2 > FOUR_Q) y2 = FOUR_Q;
      count++;
      if (count >= lim) begin
        count = lim;
        break;
      end
    end
    n = lim - count;
    d = lim - 1;
    g = (510 * n * n + d * d) / (2 * d * d);
    if (g > 255) g = 255;
    r.gray = g[7:0];
    r.count = count[15:0];
    return r;
  endfunction

  function automatic job_t blank_job();
    job_t j;
    j.is_cfg = 1'b0;
    j.drain = 1'b0;
    j.reg_idx = mep_pkg::REG_ORIGIN_X;
    j.value = '0;
    j.pix = '0;
    return j;
  endfunction

  task automatic push_pixel(logic [11:0] c, logic [11:0] r);
    job_t j;
    j = blank_job();
    j.pix = '{column: c, row: r};
    job_q.push_back(j);
  endtask

  task automatic push_write(mep_pkg::cfg_reg_t idx, logic [31:0] v);
    job_t j;
    j = blank_job();
    j.is_cfg = 1;
    j.reg_idx = idx;
    j.value = v;
    job_q.push_back(j);
  endtask

  task automatic push_drain();
    job_t j;
    j = blank_job();
    j.drain = 1;
    job_q.push_back(j);
  endtask

  // A view change: drain first, then write all four registers
  task automatic push_view(logic [31:0] ox, logic [31:0] oy, logic [31:0] st,
                           logic [31:0] lim);
    push_drain();
    push_write(mep_pkg::REG_ORIGIN_X, ox);
    push_write(mep_pkg::REG_ORIGIN_Y, oy);
    push_write(mep_pkg::REG_PIXEL_STEP, st);
    push_write(mep_pkg::REG_ITER_LIMIT, lim);
  endtask

  task automatic push_random_pixels(int n);
    repeat (n) push_pixel(12'($urandom), 12'($urandom));
  endtask

  // Stimulus list; limits stay modest, but for one deep pixel, so the run length is bounded
  initial begin
    // default view, directed corners and extremes
    push_pixel(12'd0, 12'd0);
    push_pixel(12'hFFF, 12'hFFF);
    push_pixel(12'hFFF, 12'd0);
    push_pixel(12'd0, 12'hFFF);
    push_pixel(12'd500, 12'd300);
    push_pixel(12'hAAA, 12'h555);
    push_pixel(12'h555, 12'hAAA);
    // limit below two acts as two
    push_view(32'hD800_0000, 32'hE800_0000, 32'd1342177, 32'd0);
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd300, 12'd300);
    push_drain();
    push_write(mep_pkg::REG_ITER_LIMIT, 32'd1);
    push_drain();
    push_pixel(12'd500, 12'd300);
    // zero step: every pixel is the origin (inside the set)
    push_view(32'hF800_0000, 32'd0, 32'd0, 32'd40);
    push_pixel(12'hFFF, 12'hFFF);
    push_pixel(12'd7, 12'd9);
    // saturating point: extreme origins, with the largest step and then a step of one
    push_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd8);
    push_pixel(12'd0, 12'd0);
    push_pixel(12'hFFF, 12'hFFF);
    push_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd8);
    push_pixel(12'hFFF, 12'd0);
    push_pixel(12'd1, 12'hFFF);
    // high limit on one deep pixel
    push_view(32'hF800_0000, 32'd0, 32'd0, 32'd65535);
    push_pixel(12'd0, 12'd0);
    // random views, mostly around the set so orbits run deep
    for (int v = 0; v < 12; v++) begin
      int unsigned lim;
      lim = (v % 4 == 0) ? $urandom_range(2, 4) : $urandom_range(10, 120);
      if (v % 5 == 4)
        push_view($urandom, $urandom, $urandom, lim);
      else
        push_view(32'hE000_0000 + $urandom_range(0, 32'h1000_0000),
                  32'hE800_0000 + $urandom_range(0, 32'h0800_0000),
                  $urandom_range(1, 32'h0020_0000), lim);
      push_random_pixels(95);
    end
    push_view(32'hD800_0000, 32'hE800_0000, 32'd1342177, 32'd20);
    push_random_pixels(3);
    stim_done = 1;
  end

  // Idle pattern: roughly 38 % of cycles, with a clean stretch in the middle
  function automatic bit idle_now();
    if (cycles > 60000 && cycles < 160000) return 0;
    return $urandom_range(0, 99) < 38;
  endfunction

  // Driver: pixels, register writes and drain pauses from job_q
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      pixel_ch.valid <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      cfg_write <= 1'b0;
      if (pixel_ch.valid && pixel_ch.ready) begin
        shade_q.push_back(escape_shade({pixel_ch.pixel_column, pixel_ch.pixel_row}));
        job_q.pop_front();
      end
      if (!(pixel_ch.valid && !pixel_ch.ready)) begin
        if (job_q.size() != 0 && !(pixel_ch.valid && pixel_ch.ready && 0)) begin
          job_t j;
          int k;
          k = (pixel_ch.valid && pixel_ch.ready) ? 0 : 0;
          j = job_q[k];
          if (pixel_ch.valid && pixel_ch.ready) begin
            pixel_ch.valid <= 1'b0;
          end else if (j.drain) begin
            pixel_ch.valid <= 1'b0;
            // wait out every result, then let the hold counter run out
            if (shade_q.size() == 0 && !result_ch.valid) begin
              if (hold >= 40) begin
                hold <= 0;
                job_q.pop_front();
              end else begin
                hold <= hold + 1;
              end
            end else begin
              hold <= 0;
            end
          end else if (j.is_cfg) begin
            pixel_ch.valid <= 1'b0;
            cfg_write <= 1'b1;
            cfg_index <= j.reg_idx;
            cfg_data <= j.value;
            case (j.reg_idx)
              mep_pkg::REG_ORIGIN_X:   view_x <= longint'($signed(j.value));
              mep_pkg::REG_ORIGIN_Y:   view_y <= longint'($signed(j.value));
              mep_pkg::REG_PIXEL_STEP: view_step <= longint'(j.value[30:0]);
              default:                 view_limit <= j.value[15:0];
            endcase
            job_q.pop_front();
          end else if (!idle_now()) begin
            pixel_ch.valid <= 1'b1;
            pixel_ch.pixel_column <= j.pix.column;
            pixel_ch.pixel_row <= j.pix.row;
          end else begin
            pixel_ch.valid <= 1'b0;
          end
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: consumer stalls and field-by-field check against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (shade_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          shade_t e;
          e = shade_q.pop_front();
          if (result_ch.gray_level !== e.gray) begin
            $error("gray_level expected %0d actual %0d", e.gray, result_ch.gray_level);
            errors++;
          end
          if (result_ch.iteration_count !== e.count) begin
            $error("iteration_count expected %0d actual %0d", e.count,
                   result_ch.iteration_count);
            errors++;
          end
        end
      end
      result_ch.ready <= !idle_now();
    end
  end

  // Reset, then wait for the end of stimulus and the drain
  initial begin
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel_column = '0;
    pixel_ch.pixel_row = '0;
    result_ch.ready = 1'b0;
    view_x = -64'sd671088640;
    view_y = -64'sd402653184;
    view_step = 64'sd1342177;
    view_limit = 20;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && job_q.size() == 0 && shade_q.size() == 0)
           && cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
    end else begin
      repeat (200) @(posedge clk);
      if (errors == 0 && shade_q.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end
endmodule
`default_nettype wire
